/* hw/rtl/cdtoc_pkg.sv */
// cdtoc_pkg: shared types and constants for the CD TOC position resolver.
// Used by cdtoc_msf_unit and cd_toc_position_resolver_unit; no dependencies.

package cdtoc_pkg;

	localparam int MAX_TRACKS_DEF  = 128;
	localparam int SEC_PER_MIN     = 60;
	localparam int FRAMES_PER_SEC  = 75;
	localparam int MAX_BCD_MINUTE  = 99;
	localparam int LEAD_IN_SECTORS = 150;
	localparam int DEFAULT_SPAN    = 360000;   // 80 minutes of sectors
	localparam int LOAD_SAT        = 449849;   // sector of 99:59:74
	localparam int CTRL_DATA_BIT   = 2;        // data-track bit of the control nibble

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESOLVE = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_TABLE    = 3'd1,
		ST_NO_POSITION = 3'd2,
		ST_TABLE_FULL  = 3'd3,
		ST_BAD_RANGE   = 3'd4
	} status_t;

	// configuration register indexes
	localparam logic REG_FIRST_TRACK = 1'b0;
	localparam logic REG_LAST_TRACK  = 1'b1;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  ctrl_adr_byte;
		logic [7:0]  bcd_minute_or_track;
		logic [7:0]  bcd_second;
		logic [7:0]  bcd_frame;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [19:0] start_sector;
		logic [19:0]        end_sector;
		logic               entry_is_data;
	} resp_t;

	// decoded address, from the M:S:F unit to the sequencer
	typedef struct packed {
		logic [7:0]         minute;   // binary minute or track number
		logic               msf_ok;   // M:S:F fields in range
		logic signed [20:0] sector;   // M:S:F sector less lead-in; registered, unlike minute and msf_ok
	} msf_info_t;

endpackage

/* hw/rtl/cdtoc_msf_unit.sv */
// cdtoc_msf_unit: BCD M:S:F decode and two-stage sector computation.
// Depends on cdtoc_pkg (msf_info_t and timing constants).

module cdtoc_msf_unit (
	input  logic                  clk,
	input  logic [7:0]            bcd_minute,
	input  logic [7:0]            bcd_second,
	input  logic [7:0]            bcd_frame,
	output cdtoc_pkg::msf_info_t  info
);

	// nibbles above 9 decode arithmetically too (max 165)
	function automatic logic [7:0] bcd_val(input logic [7:0] b);
		return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
	endfunction

	logic [7:0]         m_dec, s_dec, f_dec;
	logic [13:0]        ms_s1;
	logic [7:0]         f_s1;
	logic [19:0]        prod;
	logic signed [20:0] sector_s2;

	assign m_dec = bcd_val(bcd_minute);
	assign s_dec = bcd_val(bcd_second);
	assign f_dec = bcd_val(bcd_frame);

	// inputs are held stable by the caller for the whole transaction
	always_ff @(posedge clk) begin
		ms_s1 <= 14'(m_dec) * 14'(cdtoc_pkg::SEC_PER_MIN) + 14'(s_dec);
		f_s1  <= f_dec;
	end

	assign prod = 20'(ms_s1) * 20'(cdtoc_pkg::FRAMES_PER_SEC) + 20'(f_s1);

	always_ff @(posedge clk) begin
		sector_s2 <= $signed({1'b0, prod}) - 21'(cdtoc_pkg::LEAD_IN_SECTORS);
	end

	assign info.minute = m_dec;
	assign info.msf_ok = (m_dec <= 8'(cdtoc_pkg::MAX_BCD_MINUTE))
		&& (s_dec < 8'(cdtoc_pkg::SEC_PER_MIN))
		&& (f_dec < 8'(cdtoc_pkg::FRAMES_PER_SEC));
	assign info.sector = sector_s2;

endmodule

/* hw/rtl/cd_toc_position_resolver_unit.sv */
// Steps: clear and unused opcodes go straight to S_FINISH; a load passes S_CONV1, S_CONV2,
// S_EVAL and S_FINISH; a resolve ends in S_EVAL on an empty table or a bad address, else
// goes, by track via S_TRACK, to S_CHECK, then to S_SCAN if the start is not negative.
// Throughput: one transaction at a time; a resolve is bound by the scan of the track
// table through its single registered read port, one entry per cycle.
// A finished result waits in the output register; the next transaction is taken meanwhile.
// Reset (arst_n, async): entry count 0, first_track 1, last_track 0. The table RAM is
// not cleared: entries at or above the entry count are never used.

module cd_toc_position_resolver_unit #(
	parameter int MAX_TRACKS = cdtoc_pkg::MAX_TRACKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  cdtoc_pkg::req_t   in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output cdtoc_pkg::resp_t  out_data,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_data
);

	localparam int CNT_W = $clog2(MAX_TRACKS + 1);
	localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CONV1  = 8'b0000_0010,   // M:S:F stage 1
		S_CONV2  = 8'b0000_0100,   // M:S:F stage 2
		S_EVAL   = 8'b0000_1000,   // checks, table write or track lookup
		S_TRACK  = 8'b0001_0000,   // track start read data arrives
		S_CHECK  = 8'b0010_0000,
		S_SCAN   = 8'b0100_0000,   // nearest later track start
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t               state_q;
	cdtoc_pkg::req_t      req_q;
	cdtoc_pkg::resp_t     res_q, out_q;
	logic                 out_valid_q;
	logic [CNT_W-1:0]     count_q, scan_q;
	logic                 pending_q;
	logic [6:0]           first_q, last_q;
	logic signed [20:0]   start_q, end_q;

	// track table: {data flag, start sector}
	logic [20:0]          mem [MAX_TRACKS];
	logic [20:0]          rd_word_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;

	cdtoc_pkg::msf_info_t msf;

	cdtoc_msf_unit u_msf (
		.clk        (clk),
		.bcd_minute (req_q.bcd_minute_or_track),
		.bcd_second (req_q.bcd_second),
		.bcd_frame  (req_q.bcd_frame),
		.info       (msf)
	);

	// load checks
	logic [7:0]  ntracks;
	logic        bad_range, table_full;
	logic [19:0] sec_sat;
	logic        is_data;

	assign ntracks    = 8'(last_q) - 8'(first_q) + 8'd1;
	assign bad_range  = (first_q == 7'd0) || (last_q < first_q);
	assign table_full = (count_q >= CNT_W'(MAX_TRACKS)) || (8'(count_q) >= ntracks);
	assign sec_sat    = (msf.sector > 21'(cdtoc_pkg::LOAD_SAT))
		? 20'(cdtoc_pkg::LOAD_SAT) : msf.sector[19:0];
	assign is_data    = req_q.ctrl_adr_byte[cdtoc_pkg::CTRL_DATA_BIT];

	// track form of a resolve
	logic [7:0] trk_idx;
	logic       trk_in, use_track;

	assign trk_idx   = msf.minute - 8'(first_q);
	assign trk_in    = (msf.minute >= 8'(first_q)) && (msf.minute <= 8'(last_q));
	assign use_track = trk_in
		&& (!msf.msf_ok || msf.sector[20] || (req_q.bcd_second == 8'd0))
		&& (trk_idx < 8'(count_q));

	// scan issue and compare
	logic               issue;
	logic signed [20:0] t_ext;

	assign issue   = (state_q == S_SCAN) && (scan_q < count_q);
	assign t_ext   = {rd_word_q[19], rd_word_q[19:0]};
	assign rd_addr = (state_q == S_EVAL) ? trk_idx[IDX_W-1:0] : scan_q[IDX_W-1:0];
	assign mem_we  = (state_q == S_EVAL) && (req_q.opcode == cdtoc_pkg::OP_LOAD)
		&& !bad_range && !table_full;

	// write on load; read data is used only in S_TRACK and S_SCAN
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= {is_data, sec_sat};
		end
		rd_word_q <= mem[rd_addr];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			scan_q      <= '0;
			pending_q   <= 1'b0;
			first_q     <= 7'd1;
			last_q      <= 7'd0;
			start_q     <= '0;
			end_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					cdtoc_pkg::REG_FIRST_TRACK: first_q <= cfg_data;
					cdtoc_pkg::REG_LAST_TRACK:  last_q  <= cfg_data;
				endcase
			end

			// S_FINISH handles the output register itself
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						res_q <= '0;
						case (in_data.opcode)
							cdtoc_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_FINISH;
							end
							cdtoc_pkg::OP_LOAD,
							cdtoc_pkg::OP_RESOLVE: state_q <= S_CONV1;
							default:               state_q <= S_FINISH;
						endcase
					end
				end
				S_CONV1: state_q <= S_CONV2;
				S_CONV2: state_q <= S_EVAL;
				S_EVAL: begin
					if (req_q.opcode == cdtoc_pkg::OP_LOAD) begin
						if (bad_range) begin
							res_q.status <= cdtoc_pkg::ST_BAD_RANGE;
						end else if (table_full) begin
							res_q.status <= cdtoc_pkg::ST_TABLE_FULL;
						end else begin
							res_q.start_sector  <= sec_sat;
							res_q.entry_is_data <= is_data;
							count_q             <= count_q + 1'b1;
						end
						state_q <= S_FINISH;
					end else if (count_q == '0) begin
						res_q.status <= cdtoc_pkg::ST_NO_TABLE;
						state_q      <= S_FINISH;
					end else if (use_track) begin
						state_q <= S_TRACK;
					end else if (!msf.msf_ok) begin
						res_q.status <= cdtoc_pkg::ST_NO_POSITION;
						state_q      <= S_FINISH;
					end else begin
						start_q <= msf.sector;
						state_q <= S_CHECK;
					end
				end
				S_TRACK: begin
					start_q <= t_ext;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (start_q[20]) begin
						res_q.status <= cdtoc_pkg::ST_NO_POSITION;
						state_q      <= S_FINISH;
					end else begin
						end_q     <= start_q + 21'(cdtoc_pkg::DEFAULT_SPAN);
						scan_q    <= '0;
						pending_q <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					pending_q <= issue;
					// read data of the entry issued last cycle
					if (pending_q && (t_ext > start_q) && (t_ext < end_q)) begin
						end_q <= t_ext;
					end
					if (!issue && !pending_q) begin
						res_q.status       <= cdtoc_pkg::ST_OK;
						res_q.start_sector <= start_q[19:0];
						res_q.end_sector   <= end_q[19:0];
						state_q            <= S_FINISH;
					end
				end
				S_FINISH: begin
					// output register free, or emptied at this edge
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
